FILE: hw/rtl/rphc_pkg.sv
// Shared types and constants for the reflow profile heater controller.
`timescale 1ns / 1ps
package rphc_pkg;

   localparam int TEMP_W          = 10;
   localparam int DUR_W           = 16;
   localparam int SECS_W          = 20;
   localparam int MEAS_W          = 12;
   localparam int DIFF_W          = TEMP_W + 1;
   localparam int PROD_W          = DIFF_W + DUR_W + 1;
   localparam int DIVIDEND_W      = 26;
   localparam int DIV_CNT_W       = 5;

   localparam int ZONE_REGS       = 5;
   localparam int ZONE_IDX_W      = 3;
   localparam int ZONE_COUNT_DEF  = 5;
   localparam int ZONE_TARGET_LSB = 16;

   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 26;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOM_TEMP = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZONE_BASE = 3'd1;

   localparam logic [TEMP_W-1:0] ROOM_TEMP_RESET = 10'd25;

   localparam int REQ_DATA_W      = 40;
   localparam int RSP_DATA_W      = 16;

   typedef struct packed {
      logic [TEMP_W-1:0] target;
      logic [DUR_W-1:0]  dur;
   } zone_type;

   typedef struct packed {
      logic [DIVIDEND_W-1:0] quot;
      logic                  rem_nz;
   } div_res_type;

endpackage

FILE: hw/rtl/rphc_cfg_regs.sv
// Configuration registers: room temperature and the zone table with its read select.
`timescale 1ns / 1ps
module rphc_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rphc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rphc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [rphc_pkg::ZONE_IDX_W-1:0]     zone_sel,
   output rphc_pkg::zone_type                  zone,
   output logic [rphc_pkg::TEMP_W-1:0]         idle_temp
);
   import rphc_pkg::*;

   logic [TEMP_W-1:0]     room_ff;
   logic [CSR_DATA_W-1:0] zone_ff [ZONE_REGS];
   logic [CSR_ADDR_W-1:0] zone_waddr;
   logic                  zone_wr;

   assign zone_waddr = csr_addr - CSR_ZONE_BASE;
   assign zone_wr    = csr_we && (csr_addr >= CSR_ZONE_BASE)
                       && (csr_addr <= CSR_ADDR_W'(ZONE_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         room_ff <= ROOM_TEMP_RESET;
         for (int i = 0; i < ZONE_REGS; i++) begin
            zone_ff[i] <= '0;
         end
      end else begin
         if (csr_we && (csr_addr == CSR_ROOM_TEMP)) begin
            room_ff <= csr_wdata[TEMP_W-1:0];
         end
         if (zone_wr) begin
            zone_ff[zone_waddr] <= csr_wdata;
         end
      end
   end

   always_comb begin
      zone = '0;
      if (zone_sel < ZONE_IDX_W'(ZONE_REGS)) begin
         zone.target = zone_ff[zone_sel][ZONE_TARGET_LSB +: TEMP_W];
         zone.dur    = zone_ff[zone_sel][DUR_W-1:0];
      end
   end

   assign idle_temp = room_ff;

endmodule

FILE: hw/rtl/rphc_serial_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rphc_serial_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rphc_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [rphc_pkg::DUR_W-1:0]         divisor,
   output logic                               done,
   output rphc_pkg::div_res_type              result
);
   import rphc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DUR_W-1:0]      rem_ff, rem_in;
   logic [DUR_W-1:0]      divisor_ff, divisor_in;
   logic [DUR_W:0]        trial;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DUR_W'(trial - {1'b0, divisor_ff}) : trial[DUR_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done          = done_ff;
   assign result.quot   = quot_ff;
   assign result.rem_nz = |rem_ff;

endmodule

FILE: hw/rtl/reflow_profile_heater_control.sv
// Top level: sequencer for the zone scan, interpolation and heater decision.
// One update word is taken at a time; req_tready is high only while the sequencer is idle.
// An inactive update (run_active or profile_chosen low) goes from accept straight to the
// finish state. An active update scans the zones one per cycle, then passes through the
// multiply state, the divide launch state, the wait on the bit-serial divider and the
// finish state, which writes the output register once it is free. Past the last zone the
// target is the idle temperature. A finished result waits in the output register while
// the next update word is taken. Config writes apply from the next cycle on.
`timescale 1ns / 1ps
module reflow_profile_heater_control #(
   parameter int ZONE_COUNT = rphc_pkg::ZONE_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // measured_temp[11:0], elapsed_seconds[31:12], run_active[32], profile_chosen[33]
   input  logic [rphc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // heater_on[0], target_temp[10:1]
   output logic [rphc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [rphc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rphc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rphc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_DSTART,
      S_DIV,
      S_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic signed [MEAS_W-1:0] meas_ff, meas_in;
   logic [SECS_W-1:0]        secs_ff, secs_in;
   logic                     active_ff, active_in;
   logic [ZONE_IDX_W-1:0]    idx_ff, idx_in;
   logic [TEMP_W-1:0]        start_temp_ff, start_temp_in;
   logic [SECS_W-1:0]        start_time_ff, start_time_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [DUR_W-1:0]         offset_ff, offset_in;
   logic [DUR_W-1:0]         dur_ff, dur_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [TEMP_W-1:0]        target_ff, target_in;
   logic                     heater_ff, heater_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   zone_type                 zone;
   logic [TEMP_W-1:0]        idle_temp;
   logic [SECS_W-1:0]        end_time;
   logic                     hit;
   logic [PROD_W-1:0]        prod_abs;
   logic                     div_start;
   logic                     div_done;
   div_res_type              div_res;
   logic [DIFF_W-1:0]        q_mag;
   logic signed [MEAS_W-1:0] q_signed;
   logic [MEAS_W-1:0]        sum;
   logic signed [MEAS_W:0]   meas_ext;
   logic signed [MEAS_W:0]   target_ext;
   logic                     heater_next;

   rphc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .zone_sel  (idx_ff),
      .zone      (zone),
      .idle_temp (idle_temp)
   );

   rphc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[DIVIDEND_W-1:0]),
      .divisor  (dur_ff),
      .done     (div_done),
      .result   (div_res)
   );

   assign end_time    = start_time_ff + SECS_W'(zone.dur);
   assign hit         = secs_ff < end_time;
   assign prod_abs    = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign q_mag       = DIFF_W'(div_res.quot[TEMP_W-1:0])
                        + DIFF_W'(prod_ff[PROD_W-1] & div_res.rem_nz);
   assign q_signed    = prod_ff[PROD_W-1] ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
   assign sum         = MEAS_W'({2'b00, start_temp_ff}) + MEAS_W'(q_signed);
   assign meas_ext    = {meas_ff[MEAS_W-1], meas_ff};
   assign target_ext  = signed'({3'b000, target_ff});
   assign heater_next = active_ff ? (meas_ext < target_ext) : heater_ff;

   always_comb begin
      state_in      = state_ff;
      meas_in       = meas_ff;
      secs_in       = secs_ff;
      active_in     = active_ff;
      idx_in        = idx_ff;
      start_temp_in = start_temp_ff;
      start_time_in = start_time_ff;
      diff_in       = diff_ff;
      offset_in     = offset_ff;
      dur_in        = dur_ff;
      prod_in       = prod_ff;
      target_in     = target_ff;
      heater_in     = heater_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               meas_in       = req_tdata[MEAS_W-1:0];
               secs_in       = req_tdata[MEAS_W +: SECS_W];
               active_in     = req_tdata[MEAS_W+SECS_W] & req_tdata[MEAS_W+SECS_W+1];
               idx_in        = '0;
               start_temp_in = idle_temp;
               start_time_in = '0;
               target_in     = idle_temp;
               state_in      = active_in ? S_SCAN : S_FIN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               diff_in   = signed'(DIFF_W'({1'b0, zone.target}) - DIFF_W'({1'b0, start_temp_ff}));
               offset_in = DUR_W'(secs_ff - start_time_ff);
               dur_in    = zone.dur;
               state_in  = S_MUL;
            end else begin
               start_temp_in = zone.target;
               start_time_in = end_time;
               if (idx_ff == ZONE_IDX_W'(ZONE_COUNT - 1)) begin
                  target_in = idle_temp;
                  state_in  = S_FIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(diff_ff * signed'({1'b0, offset_ff}));
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               target_in = sum[TEMP_W-1:0];
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               heater_in    = heater_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({target_ff, heater_next});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         heater_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         heater_ff    <= heater_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      meas_ff       <= meas_in;
      secs_ff       <= secs_in;
      start_temp_ff <= start_temp_in;
      start_time_ff <= start_time_in;
      diff_ff       <= diff_in;
      offset_ff     <= offset_in;
      dur_ff        <= dur_in;
      prod_ff       <= prod_in;
      target_ff     <= target_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide wait");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SCAN || state_ff == S_FIN))
      else $error("accepted word did not start a scan or finish");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_res.quot[DIVIDEND_W-1:TEMP_W] == '0))
      else $error("interpolation quotient out of temperature range");

endmodule

FILE: tb/rphc_checker.sv
// Checker: predicts heater drive and profile target per update word and compares results.
`timescale 1ns / 1ps
module rphc_checker #(
   parameter int ZONE_COUNT = rphc_pkg::ZONE_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // measured_temp[11:0], elapsed_seconds[31:12], run_active[32], profile_chosen[33]
   input  logic [rphc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // heater_on[0], target_temp[10:1]
   input  logic [rphc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [rphc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rphc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   import rphc_pkg::*;

   localparam int ZONE_SLOTS = 8;

   typedef struct packed {
      logic              heater_on;
      logic [TEMP_W-1:0] target_temp;
   } drive_word_type;

   logic [TEMP_W-1:0] room_setting;
   zone_type          zone_setting [ZONE_SLOTS];
   logic              heater_now;
   drive_word_type    drive_due [$];
   int                errs = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      errs++;
   endtask

   function automatic logic [TEMP_W-1:0] profile_setpoint(input logic [SECS_W-1:0] secs);
      longint start_temp;
      longint end_temp;
      longint start_sec;
      longint end_sec;
      longint dur;
      longint num;
      longint q;
      int     i;
      start_temp = longint'(room_setting);
      start_sec  = 0;
      for (i = 0; i < ZONE_COUNT && i < ZONE_SLOTS; i++) begin
         end_temp = longint'(zone_setting[i].target);
         dur      = longint'(zone_setting[i].dur);
         end_sec  = start_sec + dur;
         if (longint'(secs) >= start_sec && longint'(secs) < end_sec) begin
            num = (end_temp - start_temp) * (longint'(secs) - start_sec);
            q   = num / dur;
            if (num < 0 && q * dur != num) q = q - 1;
            return TEMP_W'(start_temp + q);
         end
         start_temp = end_temp;
         start_sec  = end_sec;
      end
      return room_setting;
   endfunction

   always @(posedge clock) begin : watch
      drive_word_type           got;
      drive_word_type           want;
      drive_word_type           fresh;
      logic signed [MEAS_W-1:0] meas;
      logic [SECS_W-1:0]        secs;
      if (reset) begin
         room_setting = ROOM_TEMP_RESET;
         for (int i = 0; i < ZONE_SLOTS; i++) zone_setting[i] = '0;
         heater_now = 1'b0;
         drive_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_ROOM_TEMP)
               room_setting = csr_wdata[TEMP_W-1:0];
            else if (csr_addr >= CSR_ZONE_BASE && csr_addr < CSR_ZONE_BASE + ZONE_REGS)
               zone_setting[csr_addr - CSR_ZONE_BASE] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.heater_on   = rsp_tdata[0];
            got.target_temp = rsp_tdata[TEMP_W:1];
            if (drive_due.size() == 0) begin
               report_mismatch("result word with nothing due, target_temp",
                               int'(got.target_temp), -1);
            end else begin
               want = drive_due.pop_front();
               if (got.heater_on !== want.heater_on)
                  report_mismatch("heater_on", int'(got.heater_on), int'(want.heater_on));
               if (got.target_temp !== want.target_temp)
                  report_mismatch("target_temp", int'(got.target_temp),
                                  int'(want.target_temp));
            end
         end
         if (req_tvalid && req_tready) begin
            meas = req_tdata[MEAS_W-1:0];
            secs = req_tdata[MEAS_W +: SECS_W];
            fresh.target_temp = room_setting;
            if (req_tdata[MEAS_W+SECS_W] && req_tdata[MEAS_W+SECS_W+1]) begin
               fresh.target_temp = profile_setpoint(secs);
               heater_now = (int'(meas) < int'(fresh.target_temp));
            end
            fresh.heater_on = heater_now;
            drive_due.push_back(fresh);
         end
      end
      pending_count <= drive_due.size();
      fail_count    <= errs;
   end

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives update words and profile settings into the heater controller.
`timescale 1ns / 1ps
module tb_top;
   import rphc_pkg::*;

   localparam int RSP_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT      = 4000;
   localparam int SETTLE_CYCLES   = 45;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int          fail_count;
   int          pending_count;
   int          hold_requests = 0;
   int          holds_done    = 0;
   int          idle_cycles   = 0;
   bit          tx_burst      = 1'b0;
   int unsigned profile_span  = 0;
   zone_type    zone_word [ZONE_REGS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   reflow_profile_heater_control u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   rphc_checker #(
      .ZONE_COUNT (ZONE_COUNT_DEF)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic zone_type rand_zone();
      zone_type z;
      int       r;
      r = $urandom_range(0, 99);
      z.target = TEMP_W'($urandom_range(0, (1 << TEMP_W) - 1));
      if (r < 10)      z.dur = '0;
      else if (r < 80) z.dur = DUR_W'($urandom_range(1, 120));
      else if (r < 95) z.dur = DUR_W'($urandom_range(121, 2000));
      else             z.dur = DUR_W'($urandom_range(60000, (1 << DUR_W) - 1));
      return z;
   endfunction

   initial begin : rsp_side
      int run_len;
      int stall;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 8);
            rsp_tready <= 1'b1;
            repeat (run_len) @(posedge clock);
            stall = gap_len();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   task automatic send_update(input int meas, input int unsigned secs, input bit run,
                              input bit chosen);
      logic [REQ_DATA_W-1:0] word;
      int                    n;
      word = '0;
      word[MEAS_W-1:0]         = meas[MEAS_W-1:0];
      word[MEAS_W +: SECS_W]   = secs[SECS_W-1:0];
      word[MEAS_W+SECS_W]      = run;
      word[MEAS_W+SECS_W+1]    = chosen;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = tx_burst ? 0 : gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_results_in();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_profile(input logic [TEMP_W-1:0] room);
      int i;
      write_reg(CSR_ADDR_W'(CSR_ZONE_BASE + ZONE_REGS + $urandom_range(0, 1)),
                CSR_DATA_W'($urandom));
      write_reg(CSR_ROOM_TEMP, CSR_DATA_W'(room));
      profile_span = 0;
      for (i = 0; i < ZONE_REGS; i++) begin
         write_reg(CSR_ADDR_W'(CSR_ZONE_BASE + i), zone_word[i]);
         if (i < ZONE_COUNT_DEF) profile_span += 32'(zone_word[i].dur);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_updates(input int count, input bit press);
      int          k;
      int          meas;
      int unsigned secs;
      bit          run;
      bit          chosen;
      for (k = 0; k < count; k++) begin
         if (k % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
         if (press && k == 20) hold_requests++;
         if (press && k == count / 2) wait_results_in();
         if ($urandom_range(0, 1) == 0) meas = int'($urandom_range(0, 2070)) - 270;
         else                           meas = int'($urandom_range(0, 1080)) - 30;
         if ($urandom_range(0, 9) < 7) secs = $urandom_range(0, profile_span + 3);
         else                          secs = $urandom_range(0, (1 << SECS_W) - 1);
         if ($urandom_range(0, 9) < 8) begin
            run    = 1'b1;
            chosen = 1'b1;
         end else begin
            run    = 1'($urandom_range(0, 1));
            chosen = 1'($urandom_range(0, 1));
         end
         send_update(meas, secs, run, chosen);
      end
      tx_burst = 1'b0;
   endtask

   initial begin : stimulus
      int p;
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no zone covers any second
      send_update(1800, 0, 1'b0, 1'b0);
      send_update(-270, 0, 1'b1, 1'b1);
      send_update(1800, 0, 1'b1, 1'b0);
      send_update(1800, 0, 1'b0, 1'b1);
      send_update(25, (1 << SECS_W) - 1, 1'b1, 1'b1);
      wait_results_in();

      zone_word[0] = '{10'd150, 16'd90};
      zone_word[1] = '{10'd180, 16'd90};
      zone_word[2] = '{10'd245, 16'd40};
      zone_word[3] = '{10'd245, 16'd20};
      zone_word[4] = '{10'd25,  16'd60};
      load_profile(10'd25);
      send_update(24,   0,   1'b1, 1'b1);
      send_update(1800, 89,  1'b1, 1'b1);
      send_update(150,  90,  1'b1, 1'b1);
      send_update(-270, 179, 1'b1, 1'b1);
      send_update(180,  180, 1'b1, 1'b1);
      send_update(244,  220, 1'b1, 1'b1);
      send_update(245,  240, 1'b1, 1'b1);
      send_update(240,  241, 1'b1, 1'b1);
      send_update(1800, 299, 1'b1, 1'b1);
      send_update(24,   300, 1'b1, 1'b1);
      send_update(1800, 250, 1'b0, 1'b1);
      wait_results_in();

      // full-scale falling and rising zones around a zero-length zone
      zone_word[0] = '{10'd0,    16'hFFFF};
      zone_word[1] = '{10'd1023, 16'd0};
      zone_word[2] = '{10'd0,    16'd1};
      zone_word[3] = '{10'd1023, 16'hFFFF};
      zone_word[4] = '{10'd0,    16'd0};
      load_profile(10'd1023);
      send_update(1800, 0,      1'b1, 1'b1);
      send_update(-270, 65534,  1'b1, 1'b1);
      send_update(1800, 65535,  1'b1, 1'b1);
      send_update(-270, 65536,  1'b1, 1'b1);
      send_update(1022, 131070, 1'b1, 1'b1);
      send_update(1022, 131071, 1'b1, 1'b1);
      random_updates(80, 1'b0);
      wait_results_in();

      zone_word[0] = '{10'd150, 16'd90};
      zone_word[1] = '{10'd180, 16'd90};
      zone_word[2] = '{10'd245, 16'd40};
      zone_word[3] = '{10'd245, 16'd20};
      zone_word[4] = '{10'd25,  16'd60};
      load_profile(10'd25);
      random_updates(120, 1'b1);
      wait_results_in();

      for (i = 0; i < ZONE_REGS; i++) begin
         zone_word[i].target = '1;
         zone_word[i].dur    = DUR_W'($urandom_range(1, 50));
      end
      load_profile(10'd0);
      random_updates(100, 1'b0);
      wait_results_in();

      for (p = 0; p < 4; p++) begin
         for (i = 0; i < ZONE_REGS; i++) zone_word[i] = rand_zone();
         load_profile(TEMP_W'($urandom_range(0, (1 << TEMP_W) - 1)));
         random_updates(100, p == 1);
         wait_results_in();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
